// ===== src/trap_and_interrupt_entry_assert.svh =====
// Assertion macros shared by the trap entry block.
`ifndef TRAP_AND_INTERRUPT_ENTRY_ASSERT_SVH
`define TRAP_AND_INTERRUPT_ENTRY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trap entry check failed");

// Implication on the following cycle, checked outside reset.
`define TIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trap entry check failed");

`endif

// ===== src/tie_pkg.sv =====
`timescale 1ns / 1ps
package tie_pkg;

  localparam logic [1:0] PRIV_U    = 2'd0;
  localparam logic [1:0] PRIV_S    = 2'd1;
  localparam logic [1:0] PRIV_RSVD = 2'd2;
  localparam logic [1:0] PRIV_M    = 2'd3;

  localparam logic OP_EXCEPTION = 1'b0;
  localparam logic OP_IRQ_CHECK = 1'b1;

  // Status word bit positions.
  localparam int ST_SIE  = 1;
  localparam int ST_MIE  = 3;
  localparam int ST_SPIE = 5;
  localparam int ST_MPIE = 7;
  localparam int ST_SPP  = 8;
  localparam int ST_MPP  = 11;

  localparam logic [31:0] INTR_FLAG = 32'h8000_0000;
  localparam logic [1:0]  VEC_MODE_VECTORED = 2'd1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MTVEC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STVEC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDELEG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDELEG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IE_MASK = 3'd4;

  // Interrupt causes in priority order.
  localparam int NUM_SCAN = 6;
  localparam logic [4:0] SCAN_ORDER [NUM_SCAN] = '{5'd11, 5'd3, 5'd7, 5'd9, 5'd1, 5'd5};

  typedef struct packed {
    logic [31:0] mtvec;
    logic [31:0] stvec;
    logic [31:0] edeleg;
    logic [31:0] ideleg;
    logic [31:0] ie_mask;
  } tie_cfg_t;

  typedef struct packed {
    logic        operation;
    logic [4:0]  cause;
    logic [31:0] trap_value;
    logic [31:0] current_pc;
    logic [31:0] pending_bits;
  } tie_item_t;

  typedef struct packed {
    logic        trap_taken;
    logic [31:0] next_pc;
    logic [1:0]  new_privilege;
    logic [31:0] cause_word;
    logic [31:0] status_word;
  } tie_result_t;

endpackage

// ===== src/tie_if.sv =====
`timescale 1ns / 1ps
interface tie_in_if import tie_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        operation;
  logic [4:0]  cause;
  logic [31:0] trap_value;
  logic [31:0] current_pc;
  logic [31:0] pending_bits;

  modport source (output valid, operation, cause, trap_value, current_pc, pending_bits,
                  input ready);
  modport sink (input valid, operation, cause, trap_value, current_pc, pending_bits,
                output ready);
endinterface

interface tie_out_if import tie_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        trap_taken;
  logic [31:0] next_pc;
  logic [1:0]  new_privilege;
  logic [31:0] cause_word;
  logic [31:0] status_word;

  modport source (output valid, trap_taken, next_pc, new_privilege, cause_word, status_word,
                  input ready);
  modport sink (input valid, trap_taken, next_pc, new_privilege, cause_word, status_word,
                output ready);
endinterface

interface tie_cfg_if import tie_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/trap_and_interrupt_entry.sv =====
`timescale 1ns / 1ps
// Pipeline: a request is registered on acceptance and its result is registered from there into
// the output register; the scan and status update sit between the two registers.
// Throughput: one request per cycle, unless a held result on the output stalls acceptance.
// Reset (synchronous, rst_n low): privilege goes to machine mode, the status word and all
// configuration registers clear, and both pipeline registers empty.
module trap_and_interrupt_entry import tie_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  tie_in_if.sink   in_ch,
  tie_out_if.source out_ch,
  tie_cfg_if.sink  cfg_ch
);

  tie_cfg_t    cfg;
  tie_item_t   s1_item_r;
  logic        s1_valid_r;
  tie_result_t res;
  tie_result_t out_r;
  logic        out_valid_r;
  logic [1:0]  privilege_r;
  logic [31:0] mstatus_r;
  logic        out_free;
  logic        move;

  tie_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  tie_trap_logic u_trap (
    .item      (s1_item_r),
    .cfg       (cfg),
    .privilege (privilege_r),
    .mstatus   (mstatus_r),
    .res       (res)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign move        = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.operation    <= in_ch.operation;
      s1_item_r.cause        <= in_ch.cause;
      s1_item_r.trap_value   <= in_ch.trap_value;
      s1_item_r.current_pc   <= in_ch.current_pc;
      s1_item_r.pending_bits <= in_ch.pending_bits;
    end
  end

  // Architectural state advances exactly when a request's result is registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      privilege_r <= PRIV_M;
      mstatus_r   <= '0;
    end else begin
      if (move) begin
        out_valid_r <= 1'b1;
        privilege_r <= res.new_privilege;
        mstatus_r   <= res.status_word;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trap_taken    = out_r.trap_taken;
  assign out_ch.next_pc       = out_r.next_pc;
  assign out_ch.new_privilege = out_r.new_privilege;
  assign out_ch.cause_word    = out_r.cause_word;
  assign out_ch.status_word   = out_r.status_word;

  `include "trap_and_interrupt_entry_assert.svh"

  `TIE_ASSERT_NOW(a_priv_legal, 1'b1, privilege_r != PRIV_RSVD)
  `TIE_ASSERT_NEXT(a_idle_keeps_priv, move && !res.trap_taken, privilege_r == $past(privilege_r))
  `TIE_ASSERT_NEXT(a_mtrap_clears_mie, move && res.trap_taken && res.new_privilege == PRIV_M, !mstatus_r[ST_MIE])
  `TIE_ASSERT_NEXT(a_move_fills_out, move, out_valid_r)

endmodule

// ===== src/tie_cfg_regs.sv =====
`timescale 1ns / 1ps
module tie_cfg_regs import tie_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tie_cfg_if.sink   cfg_ch,
  output tie_cfg_t  cfg
);

  tie_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MTVEC:   cfg_r.mtvec   <= cfg_ch.data;
        CFG_STVEC:   cfg_r.stvec   <= cfg_ch.data;
        CFG_EDELEG:  cfg_r.edeleg  <= cfg_ch.data;
        CFG_IDELEG:  cfg_r.ideleg  <= cfg_ch.data;
        CFG_IE_MASK: cfg_r.ie_mask <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/tie_trap_logic.sv =====
`timescale 1ns / 1ps
module tie_trap_logic import tie_pkg::*; (
  input  tie_item_t   item,
  input  tie_cfg_t    cfg,
  input  logic [1:0]  privilege,
  input  logic [31:0] mstatus,
  output tie_result_t res
);

  logic [31:0]         act;
  logic [NUM_SCAN-1:0] hit;
  logic [4:0]          sel_id;
  logic                is_intr;
  logic                taken;
  logic [4:0]          c;
  logic [31:0]         deleg;
  logic                to_s;
  logic [31:0]         st;
  logic [31:0]         vec;
  logic [31:0]         base;
  logic                low_priv;

  assign act      = item.pending_bits & cfg.ie_mask;
  assign low_priv = (privilege == PRIV_U) || (privilege == PRIV_S);

  // A delegated cause is gated by SIE while in S; everything else by MIE in M.
  always_comb begin
    for (int k = 0; k < NUM_SCAN; k++) begin
      if (cfg.ideleg[SCAN_ORDER[k]] && low_priv) begin
        hit[k] = act[SCAN_ORDER[k]] && ((privilege == PRIV_U) || mstatus[ST_SIE]);
      end else begin
        hit[k] = act[SCAN_ORDER[k]] && ((privilege != PRIV_M) || mstatus[ST_MIE]);
      end
    end
  end

  always_comb begin
    sel_id = SCAN_ORDER[0];
    for (int k = NUM_SCAN - 1; k >= 0; k--) begin
      if (hit[k]) begin
        sel_id = SCAN_ORDER[k];
      end
    end
  end

  assign is_intr = (item.operation == OP_IRQ_CHECK);
  assign taken   = !is_intr || (|hit);
  assign c       = is_intr ? sel_id : item.cause;
  assign deleg   = is_intr ? cfg.ideleg : cfg.edeleg;
  assign to_s    = (privilege != PRIV_M) && deleg[c];
  assign vec     = to_s ? cfg.stvec : cfg.mtvec;
  assign base    = {vec[31:2], 2'b00};

  always_comb begin
    st = mstatus;
    if (to_s) begin
      st[ST_SPIE] = mstatus[ST_SIE];
      st[ST_SIE]  = 1'b0;
      st[ST_SPP]  = (privilege == PRIV_S);
    end else begin
      st[ST_MPIE]           = mstatus[ST_MIE];
      st[ST_MIE]            = 1'b0;
      st[ST_MPP+1:ST_MPP]   = privilege;
    end
  end

  always_comb begin
    res.trap_taken    = taken;
    res.next_pc       = item.current_pc;
    res.new_privilege = privilege;
    res.cause_word    = '0;
    res.status_word   = mstatus;
    if (taken) begin
      res.new_privilege = to_s ? PRIV_S : PRIV_M;
      res.status_word   = st;
      res.cause_word    = is_intr ? (INTR_FLAG | {27'd0, c}) : {27'd0, c};
      if (is_intr && (vec[1:0] == VEC_MODE_VECTORED)) begin
        res.next_pc = base + {25'd0, c, 2'b00};
      end else begin
        res.next_pc = base;
      end
    end
  end

endmodule
